// ===== rtl/u16u8_pkg.sv =====
// shared types and constants for the utf-16 to utf-8 encoder
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps

package u16u8_pkg;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusNeedMore = 2'd1,
    StatusInvalid  = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        final_unit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    status_e    status;
    logic       last_of_run;
  } out_item_t;

  // one classified request waiting for the byte sequencer
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    status_e         status;
  } q_entry_t;

  // push side of the queue
  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [5:0]  HighSurrTag = 6'b110110;
  localparam logic [31:0] HighBase    = 32'h0000_D800;
  localparam logic [31:0] LowBase     = 32'h0000_DC00;
  localparam logic [31:0] SuppOffset  = 32'h0001_0000;
  localparam logic [31:0] Lim1Byte    = 32'h0000_0080;
  localparam logic [31:0] Lim2Byte    = 32'h0000_0800;
  localparam logic [31:0] Lim3Byte    = 32'h0001_0000;
  localparam logic [31:0] LimValid    = 32'h0011_0000;

endpackage

// ===== rtl/utf16_to_utf8_encoder.sv =====
// top level of the utf-16 to utf-8 encoder: front end, request queue, byte sequencer
// depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back
`timescale 1ns / 1ps
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   in_data_i  (code_unit, final_unit)
//  out      output     out_valid_o / out_stall_i out_data_o (utf8_byte, status, last_of_run)
//
//  a code unit is taken every cycle while the request queue has room
//  the byte sequencer sends one result per cycle unless stalled: 1 to 4 results per unit
//  (4 for a supplementary code point), 1 for status items, 0 for a held surrogate
//  an accepted unit's first byte passes the queue entry, then the output register
//  reset empties the queue and drops any held high surrogate
//  out_stall_i holds the output register; the queue then fills and raises in_stall_o

module utf16_to_utf8_encoder import u16u8_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  // request path between the two halves
  q_push_t  push;
  q_entry_t head;
  logic     q_full, q_valid, q_pop;
  logic     in_accept;

  // front only takes a unit when its request is sure to fit
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !q_full;

  u16u8_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_data_i),
    .push_o   (push)
  );

  u16u8_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  // sequencer pops a request once its final byte is loaded
  u16u8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o),
    .out_stall_i  (out_stall_i)
  );

  // status items are single results with a zero byte
  a_status_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != StatusOk)
      |-> out_data_o.last_of_run && (out_data_o.utf8_byte == 8'h00))
    else $error("status item not a lone zero-byte result");

  // the rest of a multi-byte run is already queued, so output stays valid
  a_run_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_of_run |=> out_valid_o)
    else $error("gap inside a multi-byte run");

  // lead and continuation bytes of a run always have the top bit set
  a_multi_top_bit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == StatusOk) && !out_data_o.last_of_run
      |-> out_data_o.utf8_byte[7])
    else $error("non-final byte without top bit");

  // the sequencer can only pop what the queue holds
  a_pop_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

// ===== rtl/u16u8_front.sv =====
// front end: surrogate tracking, code point formation and byte classification
// depends on u16u8_pkg
`timescale 1ns / 1ps

module u16u8_front import u16u8_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output q_push_t  push_o
);

  logic [15:0] held_q, held_d;
  logic        is_high;
  logic [31:0] hi_off, lo_off, cp_pair, cp;
  q_entry_t    entry;

  assign is_high = (item_i.code_unit[15:10] == HighSurrTag);

  // modular 32-bit pairing, lo_off wraps when the second unit lies below the low surrogates
  assign hi_off  = {16'h0000, held_q} - HighBase;
  assign lo_off  = {16'h0000, item_i.code_unit} - LowBase;
  assign cp_pair = ((hi_off << 10) | lo_off) + SuppOffset;
  assign cp      = (held_q != 16'h0000) ? cp_pair : {16'h0000, item_i.code_unit};

  always_comb begin
    entry          = '0;
    entry.status   = StatusOk;
    if (is_high) begin
      entry.status = StatusNeedMore;
    end else if (cp < Lim1Byte) begin
      entry.bytes[0] = cp[7:0];
      entry.last_idx = 2'd0;
    end else if (cp < Lim2Byte) begin
      entry.bytes[0] = {3'b110, cp[10:6]};
      entry.bytes[1] = {2'b10, cp[5:0]};
      entry.last_idx = 2'd1;
    end else if (cp < Lim3Byte) begin
      entry.bytes[0] = {4'b1110, cp[15:12]};
      entry.bytes[1] = {2'b10, cp[11:6]};
      entry.bytes[2] = {2'b10, cp[5:0]};
      entry.last_idx = 2'd2;
    end else if (cp < LimValid) begin
      entry.bytes[0] = {5'b11110, cp[20:18]};
      entry.bytes[1] = {2'b10, cp[17:12]};
      entry.bytes[2] = {2'b10, cp[11:6]};
      entry.bytes[3] = {2'b10, cp[5:0]};
      entry.last_idx = 2'd3;
    end else begin
      entry.status = StatusInvalid;
    end
  end

  // a high surrogate without the final flag produces nothing
  assign push_o.push  = accept_i && !(is_high && !item_i.final_unit);
  assign push_o.entry = entry;

  always_comb begin
    held_d = held_q;
    if (accept_i) begin
      held_d = is_high ? item_i.code_unit : 16'h0000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 16'h0000;
    end else begin
      held_q <= held_d;
    end
  end

endmodule

// ===== rtl/u16u8_queue.sv =====
// short queue of classified requests between front end and byte sequencer
// depends on u16u8_pkg
`timescale 1ns / 1ps

module u16u8_queue import u16u8_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_push_t  push_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output q_entry_t head_o
);

  q_entry_t               mem_q [QDepth];
  logic [QPtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]       cnt_q, cnt_d;
  logic                   do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

// ===== rtl/u16u8_back.sv =====
// byte sequencer: walks the head request one byte per cycle into the output register
// while out_stall_i is low; depends on u16u8_pkg
`timescale 1ns / 1ps

module u16u8_back import u16u8_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  q_entry_t  head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  logic      out_stall_i
);

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic [1:0] idx_q, idx_d;
  logic      load, at_last;

  assign load    = !out_valid_q || !out_stall_i;
  assign at_last = (idx_q == head_i.last_idx);

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = head_valid_i;
      if (head_valid_i) begin
        out_d.utf8_byte   = head_i.bytes[idx_q];
        out_d.status      = head_i.status;
        out_d.last_of_run = at_last;
        pop_o             = at_last;
        idx_d             = at_last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
